@@ rtl/qmta_pkg.sv @@
// Shared types, constants and helper functions for the quad mesh topology audit.
// Self-contained; used by quad_mesh_topology_audit through scoped names.
package qmta_pkg;

  localparam int MAX_QUADS = 1024;
  localparam int VIDX_W    = 16;
  localparam int QIDX_W    = $clog2(MAX_QUADS);      // quad address bits
  localparam int EDGES     = 4 * MAX_QUADS;
  localparam int EIDX_W    = $clog2(EDGES);          // edge / corner address bits
  localparam int IDX_W     = EIDX_W + 1;             // counters that reach EDGES
  localparam int FACE_BASE = EDGES;                  // face parents follow the corners
  localparam int PAR_DEPTH = EDGES + MAX_QUADS;
  localparam int PAR_W     = $clog2(PAR_DEPTH);
  localparam int QUAD_W    = 4 * VIDX_W;
  localparam int PAIR_W    = 2 * VIDX_W;
  localparam int EDGE_W    = PAIR_W + 1;             // {dir, low vertex, high vertex}
  localparam int VCNT_W    = VIDX_W + 1;
  localparam int NQ_W      = QIDX_W + 1;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_INDEX    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(65536);

  typedef struct packed {
    logic [PAR_W-1:0] a;
    logic [PAR_W-1:0] b;
  } union_pair_t;

  function automatic logic [VIDX_W-1:0] corner_of(input logic [QUAD_W-1:0] q,
                                                  input logic [1:0] j);
    corner_of = q[j*VIDX_W +: VIDX_W];
  endfunction

  // Canonical vertex set of a quad: five compare-swaps.
  function automatic logic [QUAD_W-1:0] sort4(input logic [QUAD_W-1:0] q);
    logic [VIDX_W-1:0] s [4];
    logic [VIDX_W-1:0] t;
    for (int i = 0; i < 4; i++) s[i] = q[i*VIDX_W +: VIDX_W];
    if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
    if (s[2] > s[3]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
    if (s[0] > s[2]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
    if (s[1] > s[3]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
    if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
    sort4 = {s[3], s[2], s[1], s[0]};
  endfunction

  function automatic logic quad_bad(input logic [QUAD_W-1:0] q,
                                    input logic [VCNT_W-1:0] vc);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ({1'b0, q[i*VIDX_W +: VIDX_W]} >= vc) bad = 1'b1;
      for (int j = i + 1; j < 4; j++)
        if (q[i*VIDX_W +: VIDX_W] == q[j*VIDX_W +: VIDX_W]) bad = 1'b1;
    end
    quad_bad = bad;
  endfunction

  // Corner of an edge at its low (hi_end = 0) or high vertex.
  function automatic logic [PAR_W-1:0] edge_corner(input logic [EIDX_W-1:0] e,
                                                   input logic dir, input logic hi_end);
    logic [1:0] j;
    j = (dir ^ hi_end) ? e[1:0] : e[1:0] + 2'd1;
    edge_corner = PAR_W'({e[EIDX_W-1:2], j});
  endfunction

  // Union operands: 0 faces, 1 low corners, 2 high corners.
  function automatic union_pair_t union_ops(input logic [1:0] u,
                                            input logic [EIDX_W-1:0] lead, input logic ldir,
                                            input logic [EIDX_W-1:0] cur, input logic cdir);
    union_pair_t p;
    case (u)
      2'd0: begin
        p.a = PAR_W'(FACE_BASE) + PAR_W'(lead[EIDX_W-1:2]);
        p.b = PAR_W'(FACE_BASE) + PAR_W'(cur[EIDX_W-1:2]);
      end
      2'd1: begin
        p.a = edge_corner(lead, ldir, 1'b0);
        p.b = edge_corner(cur, cdir, 1'b0);
      end
      default: begin
        p.a = edge_corner(lead, ldir, 1'b1);
        p.b = edge_corner(cur, cdir, 1'b1);
      end
    endcase
    union_ops = p;
  endfunction

endpackage

@@ rtl/qmta_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module qmta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/quad_mesh_topology_audit.sv @@
// Quads load one per cycle; after the last quad, unless an error was found, the audit
// runs a duplicate scan, edge grouping and a fan scan, plus find walks of the shared
// union unit; then one result transfer.
// Throughput: one mesh at a time; input is not taken from the last quad until the
// result is taken. Pace is set by the single read port of each RAM scanned in turn.
// Reset: async active low; clears state, counters and sets the vertex count to 65536.
module quad_mesh_topology_audit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [16:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // corner0, corner1, corner2, corner3
  input  logic         s_axis_tlast,   // last_quad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // error code, vertex count echo, quad total,
                                       // repeated face count, open edge count,
                                       // overused edge count, flipped edge count,
                                       // components, split vertex count, zero pad
);

  typedef enum logic [4:0] {
    S_LOAD, S_DUP_O, S_DUP_C, S_DUP_I, S_BLD, S_FINIT, S_GRP_O, S_GRP_C, S_GRP_I,
    S_GRP_E, S_UN_RA, S_UN_CA, S_UN_RB, S_UN_CB, S_UN_W, S_COMP, S_NMV_O, S_NMV_C,
    S_NMV_I, S_OUT
  } state_e;

  localparam int IW = qmta_pkg::IDX_W;
  localparam int EW = qmta_pkg::EIDX_W;
  localparam int PW = qmta_pkg::PAR_W;

  state_e state_q, state_d;
  logic [qmta_pkg::VCNT_W-1:0] vc_q, vc_d;
  logic [qmta_pkg::NQ_W-1:0]   n_q, n_d;
  logic [1:0]                  err_q, err_d;
  logic [IW-1:0]  o_q, o_d, k_q, k_d, lim_q, lim_d, pk_q, pk_d, cnt_q, cnt_d;
  logic [EW-1:0]  lead_q, lead_d;
  logic           pv_q, pv_d, hit_q, hit_d, ldir_q, ldir_d, odir_q, odir_d;
  logic           oth_q, oth_d;
  logic [qmta_pkg::QUAD_W-1:0] ref_q, ref_d;
  logic [1:0]     u_q, u_d;
  logic [PW-1:0]  ua_q, ua_d, ub_q, ub_d;
  logic [9:0]     dup_q, dup_d;
  logic [12:0]    bnd_q, bnd_d, nmv_q, nmv_d;
  logic [11:0]    nme_q, nme_d, wind_q, wind_d;
  logic [10:0]    comp_q, comp_d;

  // RAM ports
  logic                          q_we, k_we, e_we, p_we;
  logic [qmta_pkg::QIDX_W-1:0]   q_raddr, k_raddr;
  logic [qmta_pkg::QUAD_W-1:0]   q_rdata, k_rdata;
  logic [EW-1:0]                 e_waddr, e_raddr;
  logic [qmta_pkg::EDGE_W-1:0]   e_wdata, e_rdata;
  logic [PW-1:0]                 p_waddr, p_wdata, p_raddr, p_rdata;

  logic [IW-1:0]  ne, nxt_o;
  logic           scan_more, scan_done;
  logic [qmta_pkg::VIDX_W-1:0] cp, cr;
  qmta_pkg::union_pair_t uop;

  assign ne        = {n_q, 2'b00};
  assign nxt_o     = o_q + IW'(1);
  assign scan_more = (k_q < lim_q);
  assign scan_done = !scan_more && !pv_q;

  always_comb begin
    state_d = state_q; vc_d = vc_q; n_d = n_q; err_d = err_q;
    o_d = o_q; k_d = k_q; lim_d = lim_q; pk_d = pk_q; cnt_d = cnt_q;
    lead_d = lead_q; pv_d = pv_q; hit_d = hit_q; ldir_d = ldir_q; odir_d = odir_q;
    oth_d = oth_q; ref_d = ref_q; u_d = u_q; ua_d = ua_q; ub_d = ub_q;
    dup_d = dup_q; bnd_d = bnd_q; nmv_d = nmv_q; nme_d = nme_q; wind_d = wind_q;
    comp_d = comp_q;
    q_we = 1'b0; k_we = 1'b0; e_we = 1'b0; p_we = 1'b0;
    q_raddr = k_q[EW-1:2]; k_raddr = k_q[qmta_pkg::QIDX_W-1:0];
    e_raddr = k_q[EW-1:0]; e_waddr = pk_q[EW-1:0];
    cp = qmta_pkg::corner_of(q_rdata, pk_q[1:0]);
    cr = qmta_pkg::corner_of(q_rdata, pk_q[1:0] + 2'd1);
    e_wdata = (cp < cr) ? {1'b1, cp, cr} : {1'b0, cr, cp};
    p_raddr = k_q; p_waddr = pk_q; p_wdata = pk_q;
    uop = qmta_pkg::union_ops(u_q + 2'd1, lead_q, ldir_q, o_q[EW-1:0], odir_q);

    if (cfg_we_i) vc_d = cfg_wdata_i;

    case (state_q)
      S_LOAD: begin
        if (s_axis_tvalid) begin
          if (n_q == qmta_pkg::NQ_W'(qmta_pkg::MAX_QUADS)) begin
            if (err_q == qmta_pkg::ERR_NONE) err_d = qmta_pkg::ERR_OVERFLOW;
          end else begin
            q_we = 1'b1;
            k_we = 1'b1;
            n_d  = n_q + qmta_pkg::NQ_W'(1);
            if (qmta_pkg::quad_bad(s_axis_tdata, vc_q) && err_q == qmta_pkg::ERR_NONE)
              err_d = qmta_pkg::ERR_INDEX;
          end
          if (s_axis_tlast) begin
            o_d = '0;
            state_d = (err_d != qmta_pkg::ERR_NONE) ? S_OUT : S_DUP_O;
          end
        end
      end
      S_DUP_O: begin
        k_raddr = o_q[qmta_pkg::QIDX_W-1:0];
        state_d = S_DUP_C;
      end
      S_DUP_C: begin
        ref_d = k_rdata; k_d = '0; lim_d = o_q; pv_d = 1'b0; hit_d = 1'b0;
        state_d = S_DUP_I;
      end
      S_DUP_I: begin
        k_d = scan_more ? k_q + IW'(1) : k_q; pv_d = scan_more; pk_d = k_q;
        if (pv_q && k_rdata == ref_q) hit_d = 1'b1;
        if (scan_done) begin
          if (hit_q) dup_d = dup_q + 10'd1;
          o_d = nxt_o;
          if (nxt_o == IW'(n_q)) begin
            k_d = '0; lim_d = ne; pv_d = 1'b0; state_d = S_BLD;
          end else begin
            state_d = S_DUP_O;
          end
        end
      end
      S_BLD: begin
        k_d = scan_more ? k_q + IW'(1) : k_q; pv_d = scan_more; pk_d = k_q;
        // write the edge and seed the corner parent
        if (pv_q) begin
          e_we = 1'b1;
          p_we = 1'b1;
        end
        if (scan_done) begin
          k_d = '0; lim_d = IW'(n_q); state_d = S_FINIT;
        end
      end
      S_FINIT: begin
        p_waddr = PW'(qmta_pkg::FACE_BASE) + PW'(k_q);
        p_wdata = p_waddr;
        if (scan_more) begin
          p_we = 1'b1;
          k_d = k_q + IW'(1);
        end else begin
          o_d = '0; state_d = S_GRP_O;
        end
      end
      S_GRP_O: begin
        e_raddr = o_q[EW-1:0];
        state_d = S_GRP_C;
      end
      S_GRP_C: begin
        odir_d = e_rdata[qmta_pkg::PAIR_W];
        ref_d = qmta_pkg::QUAD_W'(e_rdata[qmta_pkg::PAIR_W-1:0]);
        k_d = '0; lim_d = ne; pv_d = 1'b0; hit_d = 1'b0; cnt_d = '0;
        state_d = S_GRP_I;
      end
      S_GRP_I: begin
        k_d = scan_more ? k_q + IW'(1) : k_q; pv_d = scan_more; pk_d = k_q;
        if (pv_q && e_rdata[qmta_pkg::PAIR_W-1:0] == ref_q[qmta_pkg::PAIR_W-1:0]) begin
          cnt_d = cnt_q + IW'(1);
          // first match in index order is the group leader
          if (!hit_q) begin
            hit_d = 1'b1; lead_d = pk_q[EW-1:0]; ldir_d = e_rdata[qmta_pkg::PAIR_W];
          end
          if (pk_q != o_q) oth_d = e_rdata[qmta_pkg::PAIR_W];
        end
        if (scan_done) state_d = S_GRP_E;
      end
      S_GRP_E: begin
        if (lead_q == o_q[EW-1:0]) begin
          if (cnt_q == IW'(1)) bnd_d = bnd_q + 13'd1;
          else if (cnt_q == IW'(2)) begin
            if (oth_q == odir_q) wind_d = wind_q + 12'd1;
          end else nme_d = nme_q + 12'd1;
          o_d = nxt_o;
          if (nxt_o == ne) begin
            k_d = '0; lim_d = IW'(n_q); pv_d = 1'b0; state_d = S_COMP;
          end else begin
            state_d = S_GRP_O;
          end
        end else begin
          u_d = 2'd0;
          ua_d = qmta_pkg::PAR_W'(qmta_pkg::FACE_BASE) + PW'(lead_q[EW-1:2]);
          ub_d = qmta_pkg::PAR_W'(qmta_pkg::FACE_BASE) + PW'(o_q[EW-1:2]);
          state_d = S_UN_RA;
        end
      end
      S_UN_RA: begin
        p_raddr = ua_q; state_d = S_UN_CA;
      end
      S_UN_CA: begin
        p_raddr = ua_q;
        if (p_rdata == ua_q) state_d = S_UN_RB;
        else begin
          ua_d = p_rdata; state_d = S_UN_RA;
        end
      end
      S_UN_RB: begin
        p_raddr = ub_q; state_d = S_UN_CB;
      end
      S_UN_CB: begin
        p_raddr = ub_q;
        if (p_rdata == ub_q) state_d = S_UN_W;
        else begin
          ub_d = p_rdata; state_d = S_UN_RB;
        end
      end
      S_UN_W: begin
        // link the larger root under the smaller one
        if (ua_q < ub_q) begin
          p_we = 1'b1; p_waddr = ub_q; p_wdata = ua_q;
        end else if (ub_q < ua_q) begin
          p_we = 1'b1; p_waddr = ua_q; p_wdata = ub_q;
        end
        if (u_q == 2'd2) begin
          o_d = nxt_o;
          if (nxt_o == ne) begin
            k_d = '0; lim_d = IW'(n_q); pv_d = 1'b0; state_d = S_COMP;
          end else begin
            state_d = S_GRP_O;
          end
        end else begin
          u_d = u_q + 2'd1; ua_d = uop.a; ub_d = uop.b; state_d = S_UN_RA;
        end
      end
      S_COMP: begin
        p_raddr = PW'(qmta_pkg::FACE_BASE) + PW'(k_q);
        k_d = scan_more ? k_q + IW'(1) : k_q; pv_d = scan_more; pk_d = k_q;
        if (pv_q && p_rdata == PW'(qmta_pkg::FACE_BASE) + PW'(pk_q))
          comp_d = comp_q + 11'd1;
        if (scan_done) begin
          o_d = '0; state_d = S_NMV_O;
        end
      end
      S_NMV_O: begin
        p_raddr = o_q; q_raddr = o_q[EW-1:2];
        state_d = S_NMV_C;
      end
      S_NMV_C: begin
        if (p_rdata != o_q) begin
          o_d = nxt_o;
          state_d = (nxt_o == ne) ? S_OUT : S_NMV_O;
        end else begin
          ref_d = qmta_pkg::QUAD_W'(qmta_pkg::corner_of(q_rdata, o_q[1:0]));
          k_d = '0; lim_d = o_q; pv_d = 1'b0; cnt_d = '0;
          state_d = S_NMV_I;
        end
      end
      S_NMV_I: begin
        k_d = scan_more ? k_q + IW'(1) : k_q; pv_d = scan_more; pk_d = k_q;
        // count earlier root corners on the same vertex
        if (pv_q && p_rdata == pk_q &&
            qmta_pkg::corner_of(q_rdata, pk_q[1:0]) == ref_q[qmta_pkg::VIDX_W-1:0])
          cnt_d = cnt_q + IW'(1);
        if (scan_done) begin
          if (cnt_q == IW'(1)) nmv_d = nmv_q + 13'd1;
          o_d = nxt_o;
          state_d = (nxt_o == ne) ? S_OUT : S_NMV_O;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          n_d = '0; err_d = qmta_pkg::ERR_NONE;
          dup_d = '0; bnd_d = '0; nme_d = '0; wind_d = '0; comp_d = '0; nmv_d = '0;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; vc_q <= qmta_pkg::VCOUNT_RESET; n_q <= '0;
      err_q <= qmta_pkg::ERR_NONE;
      o_q <= '0; k_q <= '0; lim_q <= '0; pk_q <= '0; cnt_q <= '0; lead_q <= '0;
      pv_q <= 1'b0; hit_q <= 1'b0; ldir_q <= 1'b0; odir_q <= 1'b0; oth_q <= 1'b0;
      ref_q <= '0; u_q <= '0; ua_q <= '0; ub_q <= '0;
      dup_q <= '0; bnd_q <= '0; nmv_q <= '0; nme_q <= '0; wind_q <= '0; comp_q <= '0;
    end else begin
      state_q <= state_d; vc_q <= vc_d; n_q <= n_d; err_q <= err_d;
      o_q <= o_d; k_q <= k_d; lim_q <= lim_d; pk_q <= pk_d; cnt_q <= cnt_d;
      lead_q <= lead_d; pv_q <= pv_d; hit_q <= hit_d; ldir_q <= ldir_d;
      odir_q <= odir_d; oth_q <= oth_d; ref_q <= ref_d; u_q <= u_d;
      ua_q <= ua_d; ub_q <= ub_d;
      dup_q <= dup_d; bnd_q <= bnd_d; nmv_q <= nmv_d; nme_q <= nme_d;
      wind_q <= wind_d; comp_q <= comp_d;
    end
  end

  qmta_ram #(.WIDTH(qmta_pkg::QUAD_W), .DEPTH(qmta_pkg::MAX_QUADS)) u_quad_ram (
    .clk_i, .we_i(q_we), .waddr_i(n_q[qmta_pkg::QIDX_W-1:0]), .wdata_i(s_axis_tdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  qmta_ram #(.WIDTH(qmta_pkg::QUAD_W), .DEPTH(qmta_pkg::MAX_QUADS)) u_key_ram (
    .clk_i, .we_i(k_we), .waddr_i(n_q[qmta_pkg::QIDX_W-1:0]),
    .wdata_i(qmta_pkg::sort4(s_axis_tdata)), .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  qmta_ram #(.WIDTH(qmta_pkg::EDGE_W), .DEPTH(qmta_pkg::EDGES)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  qmta_ram #(.WIDTH(PW), .DEPTH(qmta_pkg::PAR_DEPTH)) u_par_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {3'b000, nmv_q, comp_q, wind_q, nme_q, bnd_q, dup_q,
                          n_q, vc_q, err_q};

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open while result pending");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && err_q != qmta_pkg::ERR_NONE) |->
      (dup_q == '0 && bnd_q == '0 && nme_q == '0 && wind_q == '0 &&
       comp_q == '0 && nmv_q == '0)) else $error("nonzero counts on error result");
  a_quad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= qmta_pkg::NQ_W'(qmta_pkg::MAX_QUADS)) else $error("quad count overrun");
  a_link_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UN_W && p_we) |-> (p_wdata < p_waddr))
    else $error("union links to a larger root");
`endif

endmodule
